>>> rtl/bbrf_pkg.sv
// shared constants, types and state codes for the row box blur
// no dependencies; imported by every rtl file of the block

package bbrf_pkg;

    localparam int MAX_RADIUS   = 31;
    localparam int CHANNEL_BITS = 16;
    localparam int RING_DEPTH   = 2 * MAX_RADIUS + 1;
    localparam int AGE_W        = $clog2(RING_DEPTH + 1);
    localparam int RADIUS_W     = 5;
    localparam int RECIP_W      = 17;
    localparam int FRAC_BITS    = 16;
    localparam int SUM_W        = CHANNEL_BITS + $clog2(RING_DEPTH);
    localparam int PROD_W       = SUM_W + RECIP_W;
    localparam int TDATA_W      = 3 * CHANNEL_BITS;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_W        = RECIP_W;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_RECIPROCAL = CFG_INDEX_W'(1);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);
    localparam logic [RECIP_W-1:0]  RECIP_RESET  = RECIP_W'(21845);

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [AGE_W-1:0]        age_t;
    typedef logic [SUM_W-1:0]        sum_t;

    // red in the low bits, as on the stream
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } pixel_t;

    typedef struct packed {
        sum_t blue;
        sum_t green;
        sum_t red;
    } sums_t;

    typedef struct packed {
        logic insert;
        logic rotate;
    } cell_ctrl_t;

    typedef struct packed {
        logic enable;
        age_t age;
        age_t back;
        age_t radius;
        age_t cap;
    } acc_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SCALE,
        ST_ROUND
    } state_t;

endpackage

>>> rtl/bbrf_cell.sv
// one stage of the pixel chain: shifts older on insert, newer on rotate
// depends on bbrf_pkg

module bbrf_cell (
    input  logic                aclk,
    input  bbrf_pkg::cell_ctrl_t ctrl,
    input  bbrf_pkg::pixel_t    lower_in,
    input  bbrf_pkg::pixel_t    upper_in,
    output bbrf_pkg::pixel_t    q
);
    import bbrf_pkg::*;

    pixel_t pix_reg;
    pixel_t pix_next;

    always_comb begin
        pix_next = pix_reg;
        if (ctrl.insert) begin
            pix_next = lower_in;
        end else if (ctrl.rotate) begin
            pix_next = upper_in;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
    end

    assign q = pix_reg;

endmodule

>>> rtl/bbrf_accum.sv
// weighted accumulate of the pixel at the chain tap, one age per cycle while enabled
// depends on bbrf_pkg

module bbrf_accum (
    input  logic                aclk,
    input  bbrf_pkg::acc_ctrl_t ctrl,
    input  bbrf_pkg::pixel_t    tap,
    output bbrf_pkg::sums_t     sums
);
    import bbrf_pkg::*;

    age_t  span;
    age_t  hi;
    age_t  weight;
    chan_t tap_ch   [3];
    logic [CHANNEL_BITS+AGE_W-1:0] term [3];
    sum_t  acc_reg  [3];
    sum_t  acc_next [3];

    // window spans ages back-radius .. back+radius; low end clamps to the
    // newest pixel, high end to the first pixel of the row (age cap)
    always_comb begin
        span   = age_t'(ctrl.back + ctrl.radius);
        hi     = (span < ctrl.cap) ? span : ctrl.cap;
        weight = age_t'(ctrl.age <= hi)
               + ((ctrl.age == '0) ? age_t'(ctrl.radius - ctrl.back) : '0)
               + ((ctrl.age == hi) ? age_t'(span - hi) : '0);
    end

    assign tap_ch[0] = tap.red;
    assign tap_ch[1] = tap.green;
    assign tap_ch[2] = tap.blue;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            // ages outside the window add nothing, whatever the cell holds
            term[c]     = (weight == '0) ? '0
                        : (CHANNEL_BITS+AGE_W)'(tap_ch[c]) * (CHANNEL_BITS+AGE_W)'(weight);
            acc_next[c] = acc_reg[c];
            if (ctrl.enable) begin
                // first age of a pass starts a fresh sum
                acc_next[c] = ((ctrl.age == '0) ? '0 : acc_reg[c]) + sum_t'(term[c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            acc_reg[c] <= acc_next[c];
        end
    end

    assign sums.red   = acc_reg[0];
    assign sums.green = acc_reg[1];
    assign sums.blue  = acc_reg[2];

endmodule

>>> rtl/bbrf_scale.sv
// window sum times q16 reciprocal, then round half up and saturate
// depends on bbrf_pkg

module bbrf_scale (
    input  logic                          aclk,
    input  logic                          load,
    input  logic [bbrf_pkg::RECIP_W-1:0]  reciprocal,
    input  bbrf_pkg::sums_t               sums,
    output bbrf_pkg::pixel_t              result
);
    import bbrf_pkg::*;

    localparam int SH_W = PROD_W + 1 - FRAC_BITS;
    localparam logic [PROD_W:0] HALF = (PROD_W+1)'(1) << (FRAC_BITS - 1);

    sum_t                sum_ch    [3];
    logic [PROD_W-1:0]   prod_reg  [3];
    logic [PROD_W-1:0]   prod_next [3];
    logic [PROD_W:0]     rounded   [3];
    logic [SH_W-1:0]     shifted   [3];
    chan_t               chan_out  [3];

    assign sum_ch[0] = sums.red;
    assign sum_ch[1] = sums.green;
    assign sum_ch[2] = sums.blue;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod_next[c] = prod_reg[c];
            if (load) begin
                prod_next[c] = PROD_W'(sum_ch[c]) * PROD_W'(reciprocal);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            prod_reg[c] <= prod_next[c];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rounded[c] = {1'b0, prod_reg[c]} + HALF;
            shifted[c] = rounded[c][PROD_W:FRAC_BITS];
            if (|shifted[c][SH_W-1:CHANNEL_BITS]) begin
                chan_out[c] = '1;
            end else begin
                chan_out[c] = shifted[c][CHANNEL_BITS-1:0];
            end
        end
    end

    assign result.red   = chan_out[0];
    assign result.green = chan_out[1];
    assign result.blue  = chan_out[2];

endmodule

>>> rtl/box_blur_row_filter.sv
// row box blur with clamped edges: top level, control and output register
// depends on bbrf_pkg, bbrf_cell, bbrf_accum, bbrf_scale
//
//   channel | ports                          | contents
//   --------+--------------------------------+--------------------------------------
//   input   | s_tvalid s_tready s_tdata s_tlast | one pixel; tlast marks the row end
//   output  | m_tvalid m_tready m_tdata m_tlast | one blurred pixel; tlast on its last
//   config  | cfg_wr_en cfg_index cfg_wdata  | 0 radius, 1 q16 reciprocal
//
// a pixel that completes no output is taken and the block stays idle; one that
// completes an output holds the input through accept, one rotation of the pixel
// chain past the single multiply-accumulate tap, scale, round and load; a row
// end repeats rotation, scale and round for each output that it owes; the round
// step waits while the output register still holds an untaken transaction
// reset is synchronous and active low; the pixel chain is not cleared, reads
// never reach entries older than the current row

module box_blur_row_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bbrf_pkg::TDATA_W-1:0]      s_tdata,   // red_in, green_in, blue_in
    input  logic                              s_tlast,   // row_end_in
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bbrf_pkg::TDATA_W-1:0]      m_tdata,   // red_out, green_out, blue_out
    output logic                              m_tlast,   // row_end_out
    // register writes
    input  logic                              cfg_wr_en,
    input  logic [bbrf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bbrf_pkg::CFG_W-1:0]        cfg_wdata
);
    import bbrf_pkg::*;

    localparam age_t LAST_AGE = age_t'(RING_DEPTH - 1);
    localparam age_t FULL_ROW = age_t'(RING_DEPTH);

    // control and configuration state
    state_t                state_reg, state_next;
    logic [RADIUS_W-1:0]   radius_reg, radius_next;
    logic [RECIP_W-1:0]    recip_reg, recip_next;
    age_t                  rp_reg, rp_next;        // pixels of the row before this one
    age_t                  cap_reg, cap_next;      // oldest age inside the row
    age_t                  back_reg, back_next;    // center of the output, ages back
    logic                  last_reg, last_next;
    age_t                  age_reg, age_next;      // age at the chain tap during rotation

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    pixel_t                m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic                  accept;
    logic                  out_free;
    logic                  load_out;
    age_t                  r_eff;
    pixel_t                new_pix;
    pixel_t                scaled;
    sums_t                 sums;
    cell_ctrl_t            cell_ctrl;
    acc_ctrl_t             acc_ctrl;
    pixel_t                cell_q [RING_DEPTH];

    assign new_pix  = pixel_t'(s_tdata);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // radius above the chain's reach is held at the maximum
    assign r_eff = (age_t'(radius_reg) > age_t'(MAX_RADIUS)) ? age_t'(MAX_RADIUS)
                                                              : age_t'(radius_reg);

    // pixel chain: cell k holds the pixel k positions older than the newest
    assign cell_ctrl.insert = accept;
    assign cell_ctrl.rotate = (state_reg == ST_ROTATE);

    for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
        localparam int UP = (i + 1) % RING_DEPTH;
        pixel_t lower;
        if (i == 0) begin : g_head
            assign lower = new_pix;
        end else begin : g_body
            assign lower = cell_q[i-1];
        end
        bbrf_cell u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .lower_in (lower),
            .upper_in (cell_q[UP]),
            .q        (cell_q[i])
        );
    end

    // one full rotation brings every age past cell 0 and restores the order
    assign acc_ctrl.enable = (state_reg == ST_ROTATE);
    assign acc_ctrl.age    = age_reg;
    assign acc_ctrl.back   = back_reg;
    assign acc_ctrl.radius = r_eff;
    assign acc_ctrl.cap    = cap_reg;

    bbrf_accum u_accum (
        .aclk (aclk),
        .ctrl (acc_ctrl),
        .tap  (cell_q[0]),
        .sums (sums)
    );

    bbrf_scale u_scale (
        .aclk       (aclk),
        .load       (state_reg == ST_SCALE),
        .reciprocal (recip_reg),
        .sums       (sums),
        .result     (scaled)
    );

    always_comb begin
        state_next  = state_reg;
        radius_next = radius_reg;
        recip_next  = recip_reg;
        rp_next     = rp_reg;
        cap_next    = cap_reg;
        back_next   = back_reg;
        last_next   = last_reg;
        age_next    = age_reg;
        s_tready    = 1'b0;
        load_out    = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_RADIUS:     radius_next = cfg_wdata[RADIUS_W-1:0];
                REG_RECIPROCAL: recip_next  = cfg_wdata[RECIP_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    // a full ring leaves the oldest slot as the clamp limit
                    cap_next = (rp_reg >= LAST_AGE) ? LAST_AGE : rp_reg;
                    age_next = '0;
                    if (s_tlast) begin
                        // row end drains every output still owed, oldest first
                        back_next  = (rp_reg < r_eff) ? rp_reg : r_eff;
                        last_next  = 1'b1;
                        rp_next    = '0;
                        state_next = ST_ROTATE;
                    end else begin
                        back_next = r_eff;
                        last_next = 1'b0;
                        if (rp_reg >= r_eff) begin
                            state_next = ST_ROTATE;
                        end
                        if (rp_reg < FULL_ROW) begin
                            rp_next = rp_reg + age_t'(1);
                        end
                    end
                end
            end
            ST_ROTATE: begin
                age_next = age_reg + age_t'(1);
                if (age_reg == LAST_AGE) begin
                    age_next   = '0;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (last_reg && back_reg != '0) begin
                        back_next  = back_reg - age_t'(1);
                        state_next = ST_ROTATE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register parts the result side from the input side
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = scaled;
            m_tlast_next  = last_reg && (back_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            radius_reg   <= RADIUS_RESET;
            recip_reg    <= RECIP_RESET;
            rp_reg       <= '0;
            last_reg     <= 1'b0;
            age_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            radius_reg   <= radius_next;
            recip_reg    <= recip_next;
            rp_reg       <= rp_next;
            last_reg     <= last_next;
            age_reg      <= age_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cap_reg     <= cap_next;
        back_reg    <= back_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // rotation walks the ages one by one without skipping
    a_rotate_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROTATE && age_reg != LAST_AGE)
        |=> (state_reg == ST_ROTATE && age_reg == $past(age_reg) + age_t'(1)))
        else $error("rotation counter skipped an age");

    // a row end always owes at least the output of its last pixel
    a_row_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == ST_ROTATE))
        else $error("row end did not start a drain");

    // final output of a row goes out flagged and the block returns to idle
    a_row_end_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && out_free && last_reg && back_reg == '0)
        |=> (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("row end transaction lost its flag");

    // row position saturates at the ring depth and the clamp limit stays inside the ring
    a_row_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (rp_reg <= FULL_ROW && cap_reg <= LAST_AGE) || state_reg == ST_IDLE)
        else $error("row position or clamp limit out of range");

endmodule

>>> tb/sv/box_blur_row_filter_tb.sv
// self-checking testbench for box_blur_row_filter, the clamped-edge row box blur
// depends on bbrf_pkg and the rtl of the block; needs no files or arguments
`timescale 1ns / 100ps

module box_blur_row_filter_tb;
    import bbrf_pkg::*;

    localparam int          HALF_PERIOD  = 4;
    localparam int          RESET_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS = 500;
    // each output takes a full chain rotation inside the block; give the tail room to settle
    localparam int          DRAIN_CYCLES = 80;
    // worst case: every item drains 32 outputs, each behind a full block pass and
    // the longest stall on both sides; taken several times over
    localparam int          LIMIT_CYCLES = 4_000_000;

    // indexes past the register list; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = CFG_INDEX_W'(3);

    // one expected blurred pixel with its row-end flag
    typedef struct packed {
        pixel_t px;
        logic   last;
    } blurred_t;

    // predictor of the row blur plus the queue of blurred pixels still owed
    class blur_checker;
        pixel_t              ring [RING_DEPTH];
        pixel_t              first_px;
        int unsigned         row_pos;
        int unsigned         wr_ptr;
        logic [RADIUS_W-1:0] radius;
        logic [RECIP_W-1:0]  recip;
        blurred_t            expected_blurred [$];
        int unsigned         errors, checked, pixels, rows, settings;
        int unsigned         rad_lo, rad_hi, recip_lo, recip_hi;

        function new();
            foreach (ring[i]) ring[i] = '0;
            first_px = '0;
            row_pos  = 0;
            wr_ptr   = 0;
            radius   = RADIUS_RESET;
            recip    = RECIP_RESET;
            rad_lo   = radius;
            rad_hi   = radius;
            recip_lo = recip;
            recip_hi = recip;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_RADIUS: begin
                    radius = val[RADIUS_W-1:0];
                    if (radius < rad_lo) rad_lo = radius;
                    if (radius > rad_hi) rad_hi = radius;
                    settings++;
                end
                REG_RECIPROCAL: begin
                    recip = val;
                    if (recip < recip_lo) recip_lo = recip;
                    if (recip > recip_hi) recip_hi = recip;
                    settings++;
                end
                default: ;
            endcase
        endfunction

        function int unsigned window_radius();
            return (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
        endfunction

        // pixel 'age' steps older than the one at wr_ptr; older than the row start
        // means the first pixel of the row (left edge clamp)
        function pixel_t fetch_aged(int unsigned age);
            if (row_pos < RING_DEPTH && age > row_pos)
                return first_px;
            return ring[(wr_ptr + RING_DEPTH - age) % RING_DEPTH];
        endfunction

        function chan_t scale_chan(logic [63:0] acc);
            logic [63:0] v;
            v = (acc * 64'(recip) + 64'd32768) >> FRAC_BITS;
            if ((v >> CHANNEL_BITS) != 0)
                return '1;
            return chan_t'(v);
        endfunction

        // mean of the window centered 'back' pixels behind the newest one;
        // offsets past the newest pixel fall back on it (right edge clamp)
        function blurred_t window_mean(int unsigned back, logic last);
            logic [63:0] acc_r, acc_g, acc_b;
            int unsigned r, age;
            pixel_t      px;
            blurred_t    res;
            r     = window_radius();
            acc_r = '0;
            acc_g = '0;
            acc_b = '0;
            for (int unsigned t = 0; t <= 2 * r; t++) begin
                age   = (back + r >= t) ? back + r - t : 0;
                px    = fetch_aged(age);
                acc_r += 64'(px.red);
                acc_g += 64'(px.green);
                acc_b += 64'(px.blue);
            end
            res.px.red   = scale_chan(acc_r);
            res.px.green = scale_chan(acc_g);
            res.px.blue  = scale_chan(acc_b);
            res.last     = last;
            return res;
        endfunction

        // an accepted input transaction: store it and queue what it completes
        function void take_pixel(pixel_t px, logic last);
            int unsigned r, start;
            r = window_radius();
            ring[wr_ptr] = px;
            if (row_pos == 0)
                first_px = px;
            pixels++;
            if (last) begin
                start = (row_pos < r) ? row_pos : r;
                for (int d = start; d >= 0; d--)
                    expected_blurred = {expected_blurred, window_mean(d, d == 0)};
                row_pos = 0;
                rows++;
            end else begin
                if (row_pos >= r)
                    expected_blurred = {expected_blurred, window_mean(r, 1'b0)};
                if (row_pos < RING_DEPTH)
                    row_pos++;
            end
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        endfunction

        function void check_blurred(pixel_t px, logic last);
            blurred_t want;
            if (expected_blurred.size() == 0) begin
                $error("output transaction with none expected: red %0d green %0d blue %0d last %0b",
                       px.red, px.green, px.blue, last);
                errors++;
                return;
            end
            want = expected_blurred.pop_front();
            checked++;
            if (px.red !== want.px.red) begin
                $error("red_out: expected %0d, actual %0d", want.px.red, px.red);
                errors++;
            end
            if (px.green !== want.px.green) begin
                $error("green_out: expected %0d, actual %0d", want.px.green, px.green);
                errors++;
            end
            if (px.blue !== want.px.blue) begin
                $error("blue_out: expected %0d, actual %0d", want.px.blue, px.blue);
                errors++;
            end
            if (last !== want.last) begin
                $error("row_end_out: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_blurred.size();
        endfunction
    endclass

    // every block input starts at a known value
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata   = '0;   // red_in, green_in, blue_in
    logic                   s_tlast   = 1'b0; // row_end_in
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;          // red_out, green_out, blue_out
    logic                   m_tlast;          // row_end_out
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    blur_checker blur_sb;
    int unsigned src_idle_pct  = 0;  // chance of a gap before each input transaction
    int unsigned sink_idle_pct = 0;  // chance of a stall burst on the output side
    int unsigned stall_left    = 0;
    int unsigned cycle_count   = 0;

    box_blur_row_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // watchdog: a hang or a lost result ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $error("timeout after %0d cycles, %0d results still owed",
                   cycle_count, blur_sb.pending());
            $display("FAIL");
            $finish;
        end
    end

    // output side back-pressure: random bursts of low tready
    always @(negedge aclk) begin
        if (stall_left == 0 && sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct)
            stall_left = $urandom_range(3, 1);
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // every output transaction is checked at the edge that takes it
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            blur_sb.check_blurred(pixel_t'(m_tdata), m_tlast);
    end

    // register write: one cycle of write enable, predictor updated at that edge
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        blur_sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one input transaction, with an optional gap of junk data in front of it;
    // tvalid stays high into the next call so back-to-back pixels see no gap
    task automatic send_pixel(pixel_t px, logic last);
        int unsigned gap;
        @(negedge aclk);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            gap = $urandom_range(3, 1);
            s_tvalid <= 1'b0;
            s_tdata  <= TDATA_W'({$urandom, $urandom});
            s_tlast  <= 1'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        blur_sb.take_pixel(px, last);
    endtask

    // drop tvalid and let every owed result come out, then let the block settle
    // so that a register write finds it idle
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (blur_sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic chan_t random_chan();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return chan_t'($urandom);
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        px.red   = random_chan();
        px.green = random_chan();
        px.blue  = random_chan();
        return px;
    endfunction

    function automatic pixel_t make_pixel(chan_t red, chan_t green, chan_t blue);
        pixel_t px;
        px.red   = red;
        px.green = green;
        px.blue  = blue;
        return px;
    endfunction

    // mostly rows that span a few windows, some no longer than the radius plus one and a few
    // longer than the store so the row position saturates
    function automatic int unsigned pick_row_len(int unsigned r);
        case ($urandom_range(9))
            0:       return $urandom_range(80, 64);
            1, 2:    return $urandom_range(r + 1, 1);
            default: return $urandom_range(2 * r + 6, 1);
        endcase
    endfunction

    function automatic int unsigned pick_idle();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 15;
            default: return 35;
        endcase
    endfunction

    initial begin
        int unsigned         random_sent;
        int unsigned         n_rows, len, r;
        logic [RECIP_W-1:0]  recip;
        logic                ragged;

        blur_sb = new();
        random_sent = 0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed part -------------------------------------------------
        src_idle_pct  = 20;
        sink_idle_pct = 20;

        // reset register values, channel extremes and alternating bit patterns
        send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000), 1'b0);
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send_pixel(make_pixel(16'hAAAA, 16'h5555, 16'hAAAA), 1'b0);
        send_pixel(make_pixel(16'h5555, 16'hAAAA, 16'h5555), 1'b1);
        // one pixel row: both edges clamp onto the same pixel
        send_pixel(make_pixel(16'hFFFF, 16'h0001, 16'h8000), 1'b1);
        wait_drained();

        // radius zero passes pixels through; upper data bits must not leak in
        write_reg(REG_RADIUS, {12'hFFF, 5'd0});
        write_reg(REG_RECIPROCAL, 17'd65536);
        send_pixel(make_pixel(16'h1234, 16'hFEDC, 16'h0F0F), 1'b0);
        send_pixel(make_pixel(16'hFFFF, 16'h0000, 16'h8000), 1'b1);
        wait_drained();

        // writes past the register list are dropped
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        // widest window on a row shorter than the radius: both edges clamped
        write_reg(REG_RADIUS, CFG_W'(MAX_RADIUS));
        write_reg(REG_RECIPROCAL, 17'd1040);
        send_pixel(make_pixel(16'hFFFF, 16'h0000, 16'h7FFF), 1'b0);
        send_pixel(random_pixel(), 1'b0);
        send_pixel(random_pixel(), 1'b0);
        send_pixel(make_pixel(16'h0000, 16'hFFFF, 16'h8001), 1'b1);
        wait_drained();

        // reciprocal far above the window weight: channels at half scale or above saturate
        write_reg(REG_RADIUS, '0);
        write_reg(REG_RECIPROCAL, '1);
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send_pixel(make_pixel(16'h0000, 16'h0001, 16'h8000), 1'b1);
        wait_drained();

        // radius widened in the middle of a row
        write_reg(REG_RADIUS, CFG_W'(2));
        write_reg(REG_RECIPROCAL, 17'd13107);
        repeat (4) send_pixel(random_pixel(), 1'b0);
        wait_drained();
        write_reg(REG_RADIUS, CFG_W'(5));
        write_reg(REG_RECIPROCAL, 17'd5958);
        repeat (3) send_pixel(random_pixel(), 1'b0);
        send_pixel(random_pixel(), 1'b1);
        wait_drained();

        // --- random part ---------------------------------------------------
        // each phase: new settings while idle, then a few rows; now and then the
        // phase stops mid-row so the next settings land inside a row
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= RANDOM_ITEMS - RANDOM_ITEMS / 6) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = pick_idle();
                sink_idle_pct = pick_idle();
            end

            case ($urandom_range(9))
                0, 1:    r = MAX_RADIUS;
                2, 3, 4: r = $urandom_range(MAX_RADIUS, 0);
                default: r = $urandom_range(4, 0);
            endcase
            if ($urandom_range(3) == 0)
                write_reg(REG_RADIUS, {12'($urandom), 5'(r)});
            else
                write_reg(REG_RADIUS, CFG_W'(r));

            // mostly the rounded weight 1/(2r+1), sometimes a mismatched one
            case ($urandom_range(9))
                0: recip = RECIP_W'($urandom_range(131071, 0));
                1: begin
                    case ($urandom_range(2))
                        0:       recip = '0;
                        1:       recip = 17'd65536;
                        default: recip = '1;
                    endcase
                end
                default: recip = RECIP_W'((65536 + (2 * r + 1) / 2) / (2 * r + 1));
            endcase
            write_reg(REG_RECIPROCAL, recip);

            if ($urandom_range(7) == 0)
                write_reg(($urandom_range(1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                          CFG_W'($urandom));

            n_rows = $urandom_range(3, 1);
            for (int k = 0; k < n_rows; k++) begin
                len    = pick_row_len(r);
                ragged = (k == n_rows - 1) && ($urandom_range(9) == 0);
                for (int i = 0; i < len; i++)
                    send_pixel(random_pixel(), !ragged && (i == len - 1));
                random_sent += len;
            end
            wait_drained();
        end

        // close any row left open so its tail is flushed and checked
        send_pixel(random_pixel(), 1'b1);
        wait_drained();

        $display("blurred %0d pixels in %0d rows over %0d register writes, %0d outputs checked",
                 blur_sb.pixels, blur_sb.rows, blur_sb.settings, blur_sb.checked);
        $display("radius spanned %0d..%0d, reciprocal spanned %0d..%0d",
                 blur_sb.rad_lo, blur_sb.rad_hi, blur_sb.recip_lo, blur_sb.recip_hi);
        if (blur_sb.errors == 0 && blur_sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/bbrf_pkg.sv
rtl/bbrf_cell.sv
rtl/bbrf_accum.sv
rtl/bbrf_scale.sv
rtl/box_blur_row_filter.sv
tb/sv/box_blur_row_filter_tb.sv
